/* hw/rtl/wtsh_pkg.sv */
// Package for the word tokenizer / shingler: shared constants, widths and codes.
// No dependencies; used by word_tokenizer_shingler_top.
`timescale 1ns / 1ps
`default_nettype none

package wtsh_pkg;

    // Letter store depth (letters kept per word)
    localparam int MAX_WORD_DEFAULT = 32;

    // Most shingles emitted for one word
    localparam int RESULT_CAP = 32;

    // Shingle geometry
    localparam int KMAX        = 8;
    localparam int BYTE_W      = 8;
    localparam int SHINGLE_W   = KMAX * BYTE_W;
    localparam int OFFSET_W    = 5;
    localparam int KLEN_W      = 4;
    localparam int MINLEN_W    = 6;
    localparam int KPOS_W      = $clog2(KMAX);

    // Stream packing
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHINGLE_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WORD_LENGTH = 1'b1;

    // Register reset values
    localparam logic [KLEN_W-1:0]   KLEN_RESET   = 4'd3;
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 6'd4;

    // ASCII letter ranges and case fold
    localparam logic [BYTE_W-1:0] UPPER_LO  = 8'd65;
    localparam logic [BYTE_W-1:0] UPPER_HI  = 8'd90;
    localparam logic [BYTE_W-1:0] LOWER_LO  = 8'd97;
    localparam logic [BYTE_W-1:0] LOWER_HI  = 8'd122;
    localparam logic [BYTE_W-1:0] CASE_FOLD = 8'd32;

endpackage

`default_nettype wire

/* hw/rtl/word_tokenizer_shingler_top.sv */
// Word tokenizer and character k-shingler, top level.
// Depends on wtsh_pkg (constants, widths, configuration register codes).
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   s_axis: one text byte per item. Letters (A-Z, a-z) are folded to lower
//   case and stored; any other byte ends the word. s_axis_tready is high only
//   while the sequencer is idle; a letter is taken without leaving idle.
//   m_axis: one item per k-letter shingle of a finished word, in order.
//   tdata = shingle (64 b) then start offset (5 b); tlast marks the final
//   shingle of the word; tuser flags a word that overran the letter store.
//   On a word end that qualifies, the sequencer walks the letter store one
//   letter per pass through the single read port: fetch, shift into the
//   window, emit. It fills the window with the first k letters, then emits
//   each shingle and shifts in the next letter; the input is held until the
//   final shingle is loaded. Non-qualifying word ends clear the word in idle.
//   The output register decouples the two sides: a stalled receiver holds
//   the current shingle and halts the sequencer in its emit step only.
//   cfg_we/cfg_index/cfg_data write shingle_length (0) or min_word_length
//   (1); write only while idle.
//   Reset (rst_n low, asynchronous) empties the word, clears the output
//   register and loads k = 3, minimum word length 4. The letter store is
//   not cleared; only letters written for the current word are read.

module word_tokenizer_shingler_top #(
    parameter int MAX_WORD = wtsh_pkg::MAX_WORD_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // byte stream in
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [wtsh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] in_byte
    // shingle stream out
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output      logic [wtsh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [63:0] shingle,
                                                                   // [68:64] offset_in_word,
                                                                   // [71:69] zero
    output      logic                              m_axis_tlast,   // last_of_word
    output      logic                              m_axis_tuser,   // [0] truncated
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [wtsh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wtsh_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W  = $clog2(MAX_WORD);
    localparam int CNT_W   = $clog2(MAX_WORD + 1);
    localparam int WIN_W   = $clog2(wtsh_pkg::RESULT_CAP + 1);
    localparam int CMP_W   = (CNT_W > wtsh_pkg::MINLEN_W) ? CNT_W : wtsh_pkg::MINLEN_W;
    localparam int WCALC_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int PAD_W   = wtsh_pkg::OUT_TDATA_W - wtsh_pkg::SHINGLE_W - wtsh_pkg::OFFSET_W;

    typedef enum logic [1:0] {
        IDLE,
        FETCH,
        LOAD,
        EMIT
    } state_t;

    // Letter store, one write and one registered read port
    logic [wtsh_pkg::BYTE_W-1:0] letter_mem [MAX_WORD];
    logic [wtsh_pkg::BYTE_W-1:0] rd_data_reg;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            ovf_reg, ovf_next;
    logic [wtsh_pkg::KLEN_W-1:0]     klen_reg, klen_next;
    logic [wtsh_pkg::MINLEN_W-1:0]   minlen_reg, minlen_next;
    logic [CNT_W-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [WIN_W-1:0]                win_idx_reg, win_idx_next;
    logic [WIN_W-1:0]                windows_reg, windows_next;
    logic [wtsh_pkg::SHINGLE_W-1:0]  window_reg, window_next;
    logic                            out_valid_reg, out_valid_next;
    logic [wtsh_pkg::SHINGLE_W-1:0]  out_shingle_reg, out_shingle_next;
    logic [wtsh_pkg::OFFSET_W-1:0]   out_offset_reg, out_offset_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_trunc_reg, out_trunc_next;

    logic [wtsh_pkg::BYTE_W-1:0]     in_byte;
    logic                            is_letter;
    logic [wtsh_pkg::BYTE_W-1:0]     lower;
    logic                            mem_we;
    logic [wtsh_pkg::KLEN_W-1:0]     k_eff;
    logic [wtsh_pkg::KPOS_W-1:0]     kpos;
    logic                            word_ok;
    logic [WCALC_W-1:0]              wins_full;
    logic [WIN_W-1:0]                windows_calc;
    logic [wtsh_pkg::SHINGLE_W-1:0]  ins_window;
    logic                            out_free;
    logic                            is_last;
    logic                            emit_load;

    assign in_byte = s_axis_tdata[wtsh_pkg::BYTE_W-1:0];

    // Letter test and case fold
    always_comb
    begin
        is_letter = 1'b0;
        lower     = in_byte;
        if (in_byte inside {[wtsh_pkg::UPPER_LO:wtsh_pkg::UPPER_HI]})
        begin
            is_letter = 1'b1;
            lower     = in_byte + wtsh_pkg::CASE_FOLD;
        end
        else if (in_byte inside {[wtsh_pkg::LOWER_LO:wtsh_pkg::LOWER_HI]})
        begin
            is_letter = 1'b1;
        end
    end

    // k clamped to 1..8
    always_comb
    begin
        if (klen_reg == '0)
            k_eff = wtsh_pkg::KLEN_W'(1);
        else if (klen_reg > wtsh_pkg::KLEN_W'(wtsh_pkg::KMAX))
            k_eff = wtsh_pkg::KLEN_W'(wtsh_pkg::KMAX);
        else
            k_eff = klen_reg;
    end

    assign kpos = wtsh_pkg::KPOS_W'(k_eff - wtsh_pkg::KLEN_W'(1));

    assign word_ok = (CMP_W'(count_reg) >= CMP_W'(minlen_reg)) &&
                     (CMP_W'(count_reg) >= CMP_W'(k_eff));

    assign wins_full = WCALC_W'(count_reg) - WCALC_W'(k_eff) + WCALC_W'(1);
    assign windows_calc = (wins_full > WCALC_W'(wtsh_pkg::RESULT_CAP)) ?
                          WIN_W'(wtsh_pkg::RESULT_CAP) : WIN_W'(wins_full);

    // Window shift: drop letter 0, new letter lands in byte k-1, bytes above stay zero
    always_comb
    begin
        for (int j = 0; j < wtsh_pkg::KMAX; j++)
        begin
            if (j == int'(kpos))
                ins_window[j*wtsh_pkg::BYTE_W +: wtsh_pkg::BYTE_W] = rd_data_reg;
            else if (j < int'(kpos))
                ins_window[j*wtsh_pkg::BYTE_W +: wtsh_pkg::BYTE_W] =
                    window_reg[(j+1)*wtsh_pkg::BYTE_W +: wtsh_pkg::BYTE_W];
            else
                ins_window[j*wtsh_pkg::BYTE_W +: wtsh_pkg::BYTE_W] = '0;
        end
    end

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign is_last   = ((win_idx_reg + WIN_W'(1)) == windows_reg);
    assign emit_load = (state_reg == EMIT) && out_free;
    assign mem_we    = (state_reg == IDLE) && s_axis_tvalid && is_letter &&
                       (count_reg < CNT_W'(MAX_WORD));

    // Sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        klen_next        = klen_reg;
        minlen_next      = minlen_reg;
        rd_ptr_next      = rd_ptr_reg;
        win_idx_next     = win_idx_reg;
        windows_next     = windows_reg;
        window_next      = window_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_shingle_next = out_shingle_reg;
        out_offset_next  = out_offset_reg;
        out_last_next    = out_last_reg;
        out_trunc_next   = out_trunc_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                wtsh_pkg::CFG_SHINGLE_LENGTH:
                    klen_next = cfg_data[wtsh_pkg::KLEN_W-1:0];
                wtsh_pkg::CFG_MIN_WORD_LENGTH:
                    minlen_next = cfg_data[wtsh_pkg::MINLEN_W-1:0];
                default:
                    ;
            endcase
        end

        case (state_reg)
            IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (is_letter)
                    begin
                        if (count_reg < CNT_W'(MAX_WORD))
                            count_next = count_reg + CNT_W'(1);
                        else
                            ovf_next = 1'b1;
                    end
                    else if (word_ok)
                    begin
                        rd_ptr_next  = '0;
                        win_idx_next = '0;
                        window_next  = '0;
                        windows_next = windows_calc;
                        state_next   = FETCH;
                    end
                    else
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end

            FETCH:
                state_next = LOAD;

            LOAD:
            begin
                window_next = ins_window;
                rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                if ((CMP_W'(rd_ptr_reg) + CMP_W'(1)) >= CMP_W'(k_eff))
                    state_next = EMIT;
                else
                    state_next = FETCH;
            end

            EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_shingle_next = window_reg;
                    out_offset_next  = win_idx_reg[wtsh_pkg::OFFSET_W-1:0];
                    out_last_next    = is_last;
                    out_trunc_next   = ovf_reg;
                    if (is_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = IDLE;
                    end
                    else
                    begin
                        win_idx_next = win_idx_reg + WIN_W'(1);
                        state_next   = FETCH;
                    end
                end
            end

            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            klen_reg        <= wtsh_pkg::KLEN_RESET;
            minlen_reg      <= wtsh_pkg::MINLEN_RESET;
            rd_ptr_reg      <= '0;
            win_idx_reg     <= '0;
            windows_reg     <= '0;
            window_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_shingle_reg <= '0;
            out_offset_reg  <= '0;
            out_last_reg    <= 1'b0;
            out_trunc_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            ovf_reg         <= ovf_next;
            klen_reg        <= klen_next;
            minlen_reg      <= minlen_next;
            rd_ptr_reg      <= rd_ptr_next;
            win_idx_reg     <= win_idx_next;
            windows_reg     <= windows_next;
            window_reg      <= window_next;
            out_valid_reg   <= out_valid_next;
            out_shingle_reg <= out_shingle_next;
            out_offset_reg  <= out_offset_next;
            out_last_reg    <= out_last_next;
            out_trunc_reg   <= out_trunc_next;
        end
    end

    // Letter store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            letter_mem[count_reg[ADDR_W-1:0]] <= lower;
        rd_data_reg <= letter_mem[rd_ptr_reg[ADDR_W-1:0]];
    end

    assign s_axis_tready = (state_reg == IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_offset_reg, out_shingle_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_trunc_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WORD))
        else $error("letter count beyond store depth");

    a_windows_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != IDLE) |->
            (windows_reg != '0) && (windows_reg <= WIN_W'(wtsh_pkg::RESULT_CAP)))
        else $error("window count out of range during emission");

    a_win_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != IDLE) |-> (win_idx_reg < windows_reg))
        else $error("shingle index passed window count");

    a_read_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FETCH) |-> (rd_ptr_reg < count_reg))
        else $error("read beyond stored letters");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && is_last) |=>
            (state_reg == IDLE) && (count_reg == '0) && out_valid_reg && out_last_reg)
        else $error("final shingle did not close the word");

endmodule

`default_nettype wire

/* sim/tb_word_tokenizer_shingler_top.sv */
// Self-checking testbench for word_tokenizer_shingler_top: byte stream in, k-letter shingles out.
// Depends on wtsh_pkg and word_tokenizer_shingler_top; a scoreboard class predicts every shingle.
`timescale 1ns / 1ps

// One shingle item as seen on the output stream
typedef struct packed {
    logic [wtsh_pkg::SHINGLE_W-1:0] shingle;
    logic [wtsh_pkg::OFFSET_W-1:0]  offset;
    logic                           last;
    logic                           truncated;
} shingle_rec_t;

function automatic bit is_letter(input logic [7:0] b);
    return (b >= wtsh_pkg::UPPER_LO && b <= wtsh_pkg::UPPER_HI) ||
           (b >= wtsh_pkg::LOWER_LO && b <= wtsh_pkg::LOWER_HI);
endfunction

// Tracks the word buffer and registers, predicts shingles, checks the output stream
class shingle_scoreboard;
    logic [7:0]                    letters [wtsh_pkg::MAX_WORD_DEFAULT];
    int unsigned                   n_letters;
    bit                            dropped;
    logic [wtsh_pkg::KLEN_W-1:0]   k_reg;
    logic [wtsh_pkg::MINLEN_W-1:0] min_reg;
    shingle_rec_t                  expected_q[$];
    int unsigned                   n_bad;

    function new();
        n_letters = 0;
        dropped   = 1'b0;
        k_reg     = wtsh_pkg::KLEN_RESET;
        min_reg   = wtsh_pkg::MINLEN_RESET;
        n_bad     = 0;
    endfunction

    function void write_reg(input logic [wtsh_pkg::CFG_IDX_W-1:0] idx,
                            input logic [wtsh_pkg::CFG_DATA_W-1:0] data);
        if (idx == wtsh_pkg::CFG_SHINGLE_LENGTH)
            k_reg = data[wtsh_pkg::KLEN_W-1:0];
        else
            min_reg = data;
    endfunction

    // Accepted text byte: store a letter, or close the word and queue its shingles
    function void note_byte(input logic [7:0] b);
        int unsigned  k;
        int unsigned  windows;
        shingle_rec_t rec;
        if (is_letter(b))
        begin
            if (n_letters < wtsh_pkg::MAX_WORD_DEFAULT)
            begin
                letters[n_letters] = (b <= wtsh_pkg::UPPER_HI) ? b + wtsh_pkg::CASE_FOLD : b;
                n_letters++;
            end
            else
                dropped = 1'b1;
            return;
        end
        k = (k_reg == 0) ? 1 : (k_reg > wtsh_pkg::KMAX) ? wtsh_pkg::KMAX : k_reg;
        if (n_letters >= min_reg && n_letters >= k)
        begin
            windows = n_letters - k + 1;
            if (windows > wtsh_pkg::RESULT_CAP)
                windows = wtsh_pkg::RESULT_CAP;
            for (int s = 0; s < windows; s++)
            begin
                rec.shingle = '0;
                for (int i = 0; i < k; i++)
                    rec.shingle[8*i +: 8] = letters[s+i];
                rec.offset    = s[wtsh_pkg::OFFSET_W-1:0];
                rec.last      = (s + 1 == windows);
                rec.truncated = dropped;
                expected_q    = {expected_q, rec};
            end
        end
        n_letters = 0;
        dropped   = 1'b0;
    endfunction

    function void check_shingle(input shingle_rec_t got);
        shingle_rec_t want;
        if (expected_q.size() == 0)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("%0t: unexpected shingle %h off %0d last %0b trunc %0b",
                         $time, got.shingle, got.offset, got.last, got.truncated);
            return;
        end
        want = expected_q.pop_front();
        if (got.shingle !== want.shingle || got.offset !== want.offset ||
            got.last !== want.last || got.truncated !== want.truncated)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("%0t: shingle exp %h/%0d/%0b/%0b got %h/%0d/%0b/%0b", $time,
                         want.shingle, want.offset, want.last, want.truncated,
                         got.shingle, got.offset, got.last, got.truncated);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_word_tokenizer_shingler_top;
    import wtsh_pkg::*;

    // Wait allowed for the sequencer to finish after the last shingle is taken.
    localparam int SETTLE_CYCLES = 120;
    // Long receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES   = 400;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] in_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [63:0] shingle, [68:64] offset_in_word, [71:69] zero
    logic                   m_axis_tlast;   // last_of_word
    logic                   m_axis_tuser;   // [0] truncated
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Percentages of cycles the sender idles and the receiver stalls
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    bit          hold_req  = 1'b0;

    shingle_scoreboard sb = new();

    word_tokenizer_shingler_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("word_tokenizer_shingler_top: mismatch");
        $finish;
    end

    // Receiver: random stalls per stall_pct; on request, a long hold-off counted here
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Output monitor: every accepted shingle goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_shingle({m_axis_tdata[SHINGLE_W-1:0],
                              m_axis_tdata[SHINGLE_W +: OFFSET_W],
                              m_axis_tlast, m_axis_tuser});
    end

    // Register write, only ever issued while the block is idle
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value[CFG_DATA_W-1:0]);
        @(posedge clk);
    endtask

    // Offer one byte, with random idle gaps first; returns on the accepting edge.
    // tvalid stays high between back-to-back items.
    task automatic feed_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(b);
    endtask

    task automatic feed_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            feed_byte(txt[i]);
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] b;
        b = 8'($urandom_range(LOWER_LO, LOWER_HI));
        if ($urandom_range(1))
            b = b - CASE_FOLD;
        return b;
    endfunction

    function automatic logic [7:0] random_delimiter();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_letter(b));
        return b;
    endfunction

    // Mostly words of random length and case closed by a random non-letter;
    // some raw noise bytes. Word length is cut so that exactly n_items go out.
    task automatic feed_random_words(input int n_items);
        int sent = 0;
        int len;
        int pick;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                pick = $urandom_range(99);
                len  = (pick < 70) ? $urandom_range(10) :
                       (pick < 90) ? $urandom_range(24, 11) : $urandom_range(40, 25);
                if (len > n_items - sent - 1)
                    len = n_items - sent - 1;
                for (int i = 0; i < len; i++)
                    feed_byte(random_letter());
                feed_byte(random_delimiter());
                sent += len + 1;
            end
            else
            begin
                feed_byte(8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // Stop offering, wait for every predicted shingle, then let the sequencer settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_phase(input int unsigned k, input int unsigned min_len,
                             input int unsigned idle, input int unsigned stall);
        write_cfg(CFG_SHINGLE_LENGTH, k);
        write_cfg(CFG_MIN_WORD_LENGTH, min_len);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers (k = 3, minimum 4): letter range edges and
        // case fold, delimiters on each side of both letter ranges, a word
        // shorter than k, one of k letters but under the minimum, empty words
        feed_text("AZaz@");
        feed_text("Hi[");
        feed_text("abc ");
        feed_text("zebra");
        feed_byte(8'd96);
        feed_text("Word{");
        feed_byte(8'h00);
        feed_byte(8'hFF);
        drain();

        // Random phases through the register range; k of 0 behaves as 1,
        // k above 8 as 8, a minimum of 0 as 1
        set_phase(1, 1, 0, 0);
        feed_random_words(12);
        drain();

        set_phase(8, 8, 73, 0);
        feed_random_words(12);
        drain();

        set_phase(0, 0, 0, 73);
        feed_random_words(12);
        drain();

        set_phase(15, 9, 30, 30);
        feed_random_words(12);
        drain();

        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the output register fills and the input stalls. Opens with a
        // word that overruns the letter store and just meets a minimum of 32.
        set_phase(7, 32, 0, 0);
        hold_req = 1'b1;
        for (int i = 0; i < 34; i++)
            feed_byte(random_letter());
        feed_byte(random_delimiter());
        feed_random_words(5);
        drain();

        // Minimum above the store size: nothing emits; the run closes on an
        // open word that must never be flushed
        set_phase(3, 63, 10, 10);
        feed_random_words(5);
        feed_text("tail");
        drain();

        if (sb.n_bad == 0 && sb.pending() == 0)
            $display("word_tokenizer_shingler_top: match");
        else
            $display("word_tokenizer_shingler_top: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/wtsh_pkg.sv
hw/rtl/word_tokenizer_shingler_top.sv
sim/tb_word_tokenizer_shingler_top.sv
